// ===== design/periodic_timer_list_engine_core_macros.svh =====
// Assertion macros used by the timer list engine sequencer.
`ifndef PERIODIC_TIMER_LIST_ENGINE_CORE_MACROS_SVH
`define PERIODIC_TIMER_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define PTLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("timer list engine: assertion failed");
// Condition that must be followed by a consequence in the next cycle.
`define PTLE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("timer list engine: sequencing assertion failed");
`else
`define PTLE_ASSERT(lbl, prop)
`define PTLE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== design/ptle_pkg.sv =====
// Types, sizes and action codes of the periodic timer list engine.
package ptle_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);

  localparam int ACT_W = 3;
  localparam int ID_W  = 16;
  localparam int PER_W = 32;
  localparam int DUE_W = 64;

  localparam logic [ACT_W-1:0] ACT_START = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

  // One list entry as held in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUE_W-1:0] due;
    logic [PER_W-1:0] period;
  } entry_t;

  // Access request from the sequencer to the entry memory.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  // One result beat.
  typedef struct packed {
    logic             ok;
    logic             fired_valid;
    logic [ID_W-1:0]  fired_id;
    logic [DUE_W-1:0] rest_ticks;
    logic             last;
  } result_t;

endpackage

// ===== design/ptle_in_if.sv =====
// Command channel of the timer list engine.
interface ptle_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptle_pkg::ACT_W-1:0]    action;
  logic [ptle_pkg::ID_W-1:0]     tmr_id;
  logic [ptle_pkg::PER_W-1:0]    period;
  logic [ptle_pkg::DUE_W-1:0]    now_tick;

  modport source (output valid, action, tmr_id, period, now_tick, input ready);
  modport sink (input valid, action, tmr_id, period, now_tick, output ready);
endinterface

// ===== design/ptle_out_if.sv =====
// Result channel of the timer list engine.
interface ptle_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          fired_valid;
  logic [ptle_pkg::ID_W-1:0]     fired_id;
  logic [ptle_pkg::DUE_W-1:0]    rest_ticks;
  logic                          last;

  modport source (output valid, ok, fired_valid, fired_id, rest_ticks, last, input ready);
  modport sink (input valid, ok, fired_valid, fired_id, rest_ticks, last, output ready);
endinterface

// ===== design/ptle_entry_mem.sv =====
// Entry memory: one write port and one registered read port.
module ptle_entry_mem (
  input  logic               clk,
  input  ptle_pkg::mem_req_t req,
  output ptle_pkg::entry_t   rd_data
);

  ptle_pkg::entry_t mem [ptle_pkg::MAX_TIMERS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/ptle_seq.sv =====
// Sequencer: walks the entry memory, rewrites entries and drives result beats.
`include "periodic_timer_list_engine_core_macros.svh"

module ptle_seq (
  input  logic               clk,
  input  logic               rst,
  ptle_in_if.sink            in_ch,
  ptle_out_if.source         out_ch,
  output ptle_pkg::mem_req_t mem_req,
  input  ptle_pkg::entry_t   rd_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                        state;
  logic [ptle_pkg::ACT_W-1:0]    act;
  logic [ptle_pkg::ID_W-1:0]     cmd_id;
  logic [ptle_pkg::PER_W-1:0]    cmd_period;
  logic [ptle_pkg::DUE_W-1:0]    now;
  logic [ptle_pkg::CNT_W-1:0]    count;
  logic [ptle_pkg::CNT_W-1:0]    rd_addr;
  logic [ptle_pkg::IDX_W-1:0]    rd_idx;
  logic                          ev_valid;
  logic                          found;
  logic [ptle_pkg::DUE_W-1:0]    rest;
  logic                          pend_valid;
  logic [ptle_pkg::ID_W-1:0]     pend_id;
  logic                          out_valid;
  ptle_pkg::result_t             out_res;

  logic                          accept;
  logic                          can_push;
  logic                          due_hit;
  logic                          id_match;
  logic                          fire_rep;
  logic                          stall;
  logic                          scan_go;
  logic                          more;
  logic                          full;
  logic                          push;
  ptle_pkg::result_t             push_res;
  logic [ptle_pkg::DUE_W-1:0]    rearm;
  logic [ptle_pkg::DUE_W-1:0]    start_due;
  logic [ptle_pkg::DUE_W-1:0]    rest_calc;

  // Handshake and entry evaluation.
  always_comb begin
    accept    = in_ch.valid && in_ch.ready;
    can_push  = !out_valid || out_ch.ready;
    due_hit   = (rd_data.period != '0) && (rd_data.due <= now);
    id_match  = (rd_data.id == cmd_id);
    rearm     = now + ptle_pkg::DUE_W'(rd_data.period);
    start_due = now + ptle_pkg::DUE_W'(cmd_period);
    rest_calc = (rd_data.due >= now) ? (rd_data.due - now) : '0;
    fire_rep  = ev_valid && (act == ptle_pkg::ACT_TICK) && due_hit && (rd_data.id != '0);
    stall     = fire_rep && pend_valid && !can_push;
    scan_go   = (state == S_SCAN) && !stall;
    more      = (rd_addr < count);
    full      = (count >= ptle_pkg::CNT_W'(ptle_pkg::MAX_TIMERS));
  end

  // Result beat selection.
  always_comb begin
    push     = 1'b0;
    push_res = '0;
    case (state)
      S_SCAN: begin
        // A new fired id releases the one held back, which is then not the last.
        if (scan_go && fire_rep && pend_valid) begin
          push                 = 1'b1;
          push_res.fired_valid = 1'b1;
          push_res.fired_id    = pend_id;
        end
      end
      S_DONE: begin
        push          = can_push;
        push_res.last = 1'b1;
        case (act)
          ptle_pkg::ACT_START: push_res.ok = !full;
          ptle_pkg::ACT_STOP:  push_res.ok = found;
          ptle_pkg::ACT_QUERY: push_res.rest_ticks = rest;
          ptle_pkg::ACT_TICK: begin
            push_res.fired_valid = pend_valid;
            push_res.fired_id    = pend_valid ? pend_id : '0;
          end
          default: push_res.ok = 1'b0;
        endcase
      end
      default: push = 1'b0;
    endcase
  end

  // Memory requests.
  always_comb begin
    mem_req = '0;
    if (scan_go && more) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = rd_addr[ptle_pkg::IDX_W-1:0];
    end
    if (scan_go && ev_valid) begin
      if ((act == ptle_pkg::ACT_TICK) && due_hit) begin
        mem_req.wr_en          = 1'b1;
        mem_req.wr_addr        = rd_idx;
        mem_req.wr_data.id     = rd_data.id;
        mem_req.wr_data.due    = rearm;
        mem_req.wr_data.period = rd_data.period;
      end else if ((act == ptle_pkg::ACT_STOP) && found) begin
        // Close the gap: each later entry moves down by one place.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = rd_idx - ptle_pkg::IDX_W'(1);
        mem_req.wr_data = rd_data;
      end
    end
    if ((state == S_DONE) && can_push && (act == ptle_pkg::ACT_START) && !full) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = count[ptle_pkg::IDX_W-1:0];
      if (cmd_period != '0) begin
        mem_req.wr_data.id     = cmd_id;
        mem_req.wr_data.due    = start_due;
        mem_req.wr_data.period = cmd_period;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_res   <= push_res;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Command sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ev_valid   <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            act        <= in_ch.action;
            cmd_id     <= in_ch.tmr_id;
            cmd_period <= in_ch.period;
            now        <= in_ch.now_tick;
            rd_addr    <= '0;
            rest       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            ev_valid   <= 1'b0;
            if (in_ch.action inside {ptle_pkg::ACT_STOP, ptle_pkg::ACT_QUERY,
                                     ptle_pkg::ACT_TICK}) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            ev_valid <= more;
            if (more) begin
              rd_addr <= rd_addr + ptle_pkg::CNT_W'(1);
              rd_idx  <= rd_addr[ptle_pkg::IDX_W-1:0];
            end else begin
              state <= S_DONE;
            end
            if (ev_valid && !found && id_match &&
                (act == ptle_pkg::ACT_STOP || act == ptle_pkg::ACT_QUERY)) begin
              found <= 1'b1;
              rest  <= rest_calc;
            end
            if (fire_rep) begin
              pend_valid <= 1'b1;
              pend_id    <= rd_data.id;
            end
          end
        end
        S_DONE: begin
          if (can_push) begin
            state <= S_IDLE;
            if ((act == ptle_pkg::ACT_START) && !full) begin
              count <= count + ptle_pkg::CNT_W'(1);
            end else if ((act == ptle_pkg::ACT_STOP) && found) begin
              count <= count - ptle_pkg::CNT_W'(1);
            end else if (act == ptle_pkg::ACT_CLEAR) begin
              count <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Channel drive.
  always_comb begin
    in_ch.ready        = (state == S_IDLE);
    out_ch.valid       = out_valid;
    out_ch.ok          = out_res.ok;
    out_ch.fired_valid = out_res.fired_valid;
    out_ch.fired_id    = out_res.fired_id;
    out_ch.rest_ticks  = out_res.rest_ticks;
    out_ch.last        = out_res.last;
  end

  `PTLE_ASSERT(a_count_bound, count <= ptle_pkg::CNT_W'(ptle_pkg::MAX_TIMERS))
  `PTLE_ASSERT(a_scan_wr_in_list, (state == S_SCAN && mem_req.wr_en) |-> (ptle_pkg::CNT_W'(mem_req.wr_addr) < count))
  `PTLE_ASSERT(a_pend_tick_only, pend_valid |-> (act == ptle_pkg::ACT_TICK))
  `PTLE_ASSERT(a_idle_no_push, (state == S_IDLE) |-> !push)
  `PTLE_ASSERT_NEXT(a_done_to_idle, state == S_DONE && can_push, state == S_IDLE)

endmodule

// ===== design/periodic_timer_list_engine_core.sv =====
// Top level of the periodic timer list engine.
//
// Commands arrive as beats on in_ch (action, tmr_id, period, now_tick) and
// results leave as beats on out_ch; the final beat of a command has last set.
// Start, clear and unused codes go straight to the done state for one beat.
// Stop, query and tick walk the list through the entry memory, one read per
// cycle while the walk is not paused, each read result being registered in
// the entry memory before it is handled. A tick gives one beat per fired
// timer with a nonzero id, or a single beat with fired_valid low when none
// fired. The entry memory has one read and one write port, and a stop moves
// each later entry down one place as it passes. A new command is taken only
// once the previous one has handed over its last beat; that beat may still
// wait in the output register. When the receiver stalls, the walk pauses on
// the entry that would need a second beat in flight and resumes as soon as
// the output register frees. Reset empties the list; entry contents are not
// cleared and need no pass.
module periodic_timer_list_engine_core (
  input  logic       clk,
  input  logic       rst,
  ptle_in_if.sink    in_ch,
  ptle_out_if.source out_ch
);

  ptle_pkg::mem_req_t mem_req;
  ptle_pkg::entry_t   rd_data;

  // Command sequencer and result register.
  ptle_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Timer entry storage.
  ptle_entry_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
